### hdl/lifo_kd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_kd_pkg
// shared sizes, codes and controller/datapath interface types for the
// bounded key stack with keyed delete
// ----------------------------------------------------------------------------
package lifo_kd_pkg;

  localparam int unsigned DEPTH    = 8;
  localparam int unsigned KEY_BITS = 64;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // fixed field widths of the stream ports
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned CAR_KEY_W    = 64;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned ENTRY_CNT_W  = 4;
  localparam int unsigned IN_TDATA_W   = 64;
  localparam int unsigned OUT_TDATA_W  = 8;

  // operation codes, code three decodes as a search since it is neither push nor remove
  localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_PRESENT   = 3'd5
  } status_e;

  typedef struct packed {
    logic    ld_in;       // capture operation and key
    logic    push_wr;     // write key on top and bump the count
    logic    idx_ld_top;  // point the index at the top entry
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;       // read entry at index into the read register
    logic    shift_wr;    // move read register one slot down
    logic    cnt_dec;
    logic    set_st;
    status_e st;
    logic    out_ld;      // load the result register
  } cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_remove;
    logic full;
    logic empty;
    logic hit;
    logic idx_zero;
    logic shift_more;     // an entry above the index still has to move down
  } sts_t;

endpackage

### hdl/lifo_table_with_keyed_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_table_with_keyed_delete
// bounded stack of keys with push, topmost-match remove with compaction,
// and search; one result word per input word
// ----------------------------------------------------------------------------
//
// channel   dir  tdata             tuser
// s_axis    in   car_key[63:0]     func[1:0]
// m_axis    out  entry_count[3:0]  status[2:0]
//
// one word at a time through a key store with one write port and a registered read:
// push, full and empty cases go from accept through decode to the result load;
// a scan reads and then compares each entry examined, compaction reads and then
// writes each entry moved, and the controller returns to idle after each load
// reset clears the count and the result valid; the store itself is not cleared
// a stalled result holds in its register; the next word is taken once the
// previous result is loaded there
// ----------------------------------------------------------------------------
module lifo_table_with_keyed_delete (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lifo_kd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // car_key
  input  logic [lifo_kd_pkg::FUNC_W-1:0]       s_axis_tuser,   // func
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lifo_kd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // entry_count, zero pad
  output logic [lifo_kd_pkg::STATUS_W-1:0]     m_axis_tuser    // status
);

  lifo_kd_pkg::cmd_t                   cmd;
  lifo_kd_pkg::sts_t                   sts;
  logic [lifo_kd_pkg::ENTRY_CNT_W-1:0] entry_count;

  lifo_kd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lifo_kd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (s_axis_tuser),
    .car_key_i     (s_axis_tdata[lifo_kd_pkg::CAR_KEY_W-1:0]),
    .status_o      (m_axis_tuser),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = lifo_kd_pkg::OUT_TDATA_W'(entry_count);

endmodule

### hdl/lifo_kd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_kd_dp
// datapath: key store, count, scan index, compare and result register
// ----------------------------------------------------------------------------
module lifo_kd_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lifo_kd_pkg::cmd_t                    cmd_i,
  output lifo_kd_pkg::sts_t                    sts_o,
  input  logic [lifo_kd_pkg::FUNC_W-1:0]       func_i,
  input  logic [lifo_kd_pkg::CAR_KEY_W-1:0]    car_key_i,
  output logic [lifo_kd_pkg::STATUS_W-1:0]     status_o,
  output logic [lifo_kd_pkg::ENTRY_CNT_W-1:0]  entry_count_o
);

  logic [lifo_kd_pkg::KEY_BITS-1:0] mem [lifo_kd_pkg::DEPTH];

  logic [lifo_kd_pkg::FUNC_W-1:0]      func_q;
  logic [lifo_kd_pkg::KEY_BITS-1:0]    key_q;
  logic [lifo_kd_pkg::KEY_BITS-1:0]    rdata_q;
  logic [lifo_kd_pkg::CNT_W-1:0]       count_q, count_d;
  logic [lifo_kd_pkg::IDX_W-1:0]       idx_q, idx_d;
  lifo_kd_pkg::status_e                st_q;
  logic [lifo_kd_pkg::STATUS_W-1:0]    out_status_q;
  logic [lifo_kd_pkg::ENTRY_CNT_W-1:0] out_count_q;
  logic                                wr_en;
  logic [lifo_kd_pkg::IDX_W-1:0]       wr_addr;
  logic [lifo_kd_pkg::KEY_BITS-1:0]    wr_data;
  logic [lifo_kd_pkg::CNT_W-1:0]       idx_ext;

  assign idx_ext = lifo_kd_pkg::CNT_W'(idx_q);

  assign sts_o.is_push    = (func_q == lifo_kd_pkg::OP_PUSH);
  assign sts_o.is_remove  = (func_q == lifo_kd_pkg::OP_REMOVE);
  assign sts_o.full       = (count_q == lifo_kd_pkg::CNT_W'(lifo_kd_pkg::DEPTH));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.hit        = (rdata_q == key_q);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.shift_more = ((idx_ext + lifo_kd_pkg::CNT_W'(1)) < count_q);

  always_comb begin
    count_d = count_q;
    if (cmd_i.push_wr) begin
      count_d = count_q + lifo_kd_pkg::CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - lifo_kd_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_ld_top) begin
      idx_d = lifo_kd_pkg::IDX_W'(count_q - lifo_kd_pkg::CNT_W'(1));
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + lifo_kd_pkg::IDX_W'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - lifo_kd_pkg::IDX_W'(1);
    end
  end

  // one write port: push goes on top, compaction writes one below the index
  always_comb begin
    wr_en   = cmd_i.push_wr | cmd_i.shift_wr;
    wr_addr = cmd_i.push_wr ? lifo_kd_pkg::IDX_W'(count_q) : idx_q - lifo_kd_pkg::IDX_W'(1);
    wr_data = cmd_i.push_wr ? key_q : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.ld_in) begin
      func_q <= func_i;
      key_q  <= car_key_i[lifo_kd_pkg::KEY_BITS-1:0];
    end
    if (cmd_i.set_st) begin
      st_q <= cmd_i.st;
    end
    if (cmd_i.out_ld) begin
      out_status_q <= st_q;
      out_count_q  <= lifo_kd_pkg::ENTRY_CNT_W'(count_q);
    end
  end

  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

endmodule

### hdl/lifo_kd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_kd_ctrl
// controller: sequences decode, top-down scan, compaction and the result
// ----------------------------------------------------------------------------
module lifo_kd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lifo_kd_pkg::cmd_t cmd_o,
  input  lifo_kd_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    cmd_o.st = lifo_kd_pkg::ST_NOT_FOUND;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.set_st = 1'b1;
        state_d      = S_RESP;
        if (sts_i.is_push) begin
          if (sts_i.full) begin
            cmd_o.st = lifo_kd_pkg::ST_FULL;
          end else begin
            cmd_o.push_wr = 1'b1;
            cmd_o.st      = lifo_kd_pkg::ST_PUSHED;
          end
        end else if (sts_i.empty) begin
          cmd_o.st = sts_i.is_remove ? lifo_kd_pkg::ST_EMPTY : lifo_kd_pkg::ST_NOT_FOUND;
        end else begin
          cmd_o.set_st     = 1'b0;
          cmd_o.idx_ld_top = 1'b1;
          state_d          = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.set_st = 1'b1;
          if (!sts_i.is_remove) begin
            cmd_o.st = lifo_kd_pkg::ST_PRESENT;
            state_d  = S_RESP;
          end else if (sts_i.shift_more) begin
            cmd_o.set_st  = 1'b0;
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SH_RD;
          end else begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.st      = lifo_kd_pkg::ST_REMOVED;
            state_d       = S_RESP;
          end
        end else if (sts_i.idx_zero) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = lifo_kd_pkg::ST_NOT_FOUND;
          state_d      = S_RESP;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_RD;
        end
      end
      S_SH_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        if (sts_i.shift_more) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SH_RD;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.set_st  = 1'b1;
          cmd_o.st      = lifo_kd_pkg::ST_REMOVED;
          state_d       = S_RESP;
        end
      end
      S_RESP: begin
        // result register free or being drained this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
